// ===== rtl/spisfr_pkg.sv =====
// Types and constants shared by the SPI star frame relay.
package spisfr_pkg;

    // hub state, one-hot
    typedef enum logic [4:0] {
        ST_POLL = 5'b00001,
        ST_RECV = 5'b00010,
        ST_HAND = 5'b00100,
        ST_SEND = 5'b01000,
        ST_BCST = 5'b10000
    } t_state;

    // input item kinds
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_XFER  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // phase codes shown on the result
    localparam logic [2:0] PH_POLL = 3'd0;
    localparam logic [2:0] PH_RECV = 3'd1;
    localparam logic [2:0] PH_HAND = 3'd2;
    localparam logic [2:0] PH_SEND = 3'd3;
    localparam logic [2:0] PH_BCST = 3'd4;

    localparam logic [2:0] SEL_HOST = 3'd0;
    localparam logic [2:0] SEL_NONE = 3'd5;
    localparam logic [2:0] MAX_PEERS = 3'd5;

    // configuration register indexes
    localparam logic REG_POLL_WINDOW  = 1'b0;
    localparam logic REG_POLLED_PEERS = 1'b1;

    // protocol bytes
    localparam logic [7:0] B_POLL      = 8'h06;
    localparam logic [7:0] B_POLL_ACK  = 8'h60;
    localparam logic [7:0] B_HAND      = 8'hA6;
    localparam logic [7:0] B_HAND_ACK  = 8'h6F;
    localparam logic [7:0] B_FILL      = 8'h55;
    localparam logic [7:0] T_DIRECT    = 8'hEE;
    localparam logic [7:0] T_HOST      = 8'hDD;
    localparam logic [7:0] T_BCAST     = 8'hCC;
    localparam logic [7:0] T_DIR_BCAST = 8'hBB;
    localparam logic [7:0] A_HOST      = 8'hA6;
    localparam logic [7:0] A_CLI_LO    = 8'hA1;
    localparam logic [7:0] A_CLI_HI    = 8'hA4;
    localparam logic [7:0] A_CLI_BASE  = 8'hA0;

    localparam logic [15:0] WINDOW_RESET = 16'd11500;
    localparam logic [15:0] TIMER_MAX    = 16'hFFFF;
    localparam logic [2:0]  PEERS_RESET  = 3'd3;
    localparam logic [2:0]  BCST_CLIENTS = 3'd4;

    function automatic logic [2:0] addr_to_peer(input logic [7:0] a);
        logic [7:0] d;
        d = a - A_CLI_BASE;
        if (a == A_HOST) begin
            return SEL_HOST;
        end else if (a >= A_CLI_LO && a <= A_CLI_HI) begin
            return d[2:0];
        end else begin
            return SEL_NONE;
        end
    endfunction

endpackage

// ===== rtl/spi_star_frame_relay.sv =====
// SPI star hub: polls peers in turn and relays the frames they send.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: miso_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: mosi_byte;
//                                               tuser: peer_select, phase;
//                                               tlast: frame_last
//  cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One item per cycle unless a result stalls. Each item is registered on
// input; state update and result form in one pass into the output register.
// Body bytes come from a 1R1W frame buffer read one step ahead, so a relay
// byte is ready when sent. Reset is synchronous; the frame buffer is not
// cleared. A stalled result holds the pass; ticks pass even while stalled.
module spi_star_frame_relay #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] miso_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] mosi_byte
    output logic [5:0]  m_axis_tuser,   // [2:0] peer_select, [5:3] phase
    output logic        m_axis_tlast    // frame_last
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam logic [8:0] BUF_CNT = 9'(BUFFER_BYTES);

    // configuration
    logic [15:0] r_poll_window;
    logic [2:0]  r_polled_peers;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_action;
    logic [7:0] r_in_rx;

    // hub state
    spisfr_pkg::t_state r_state, n_state;
    logic [2:0]  r_peer, n_peer;
    logic [15:0] r_timer, n_timer;
    logic        r_expired, n_expired;
    logic [8:0]  r_count, n_count;
    logic [2:0]  r_target, n_target;
    logic [2:0]  r_bidx, n_bidx;
    logic        r_bafter, n_bafter;

    // frame header bytes and body buffer
    logic [7:0] r_hdr [4];
    logic [7:0] r_mem [BUFFER_BYTES];
    logic [7:0] r_rd;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_mosi;
    logic [2:0] r_out_sel;
    logic [2:0] r_out_ph;
    logic       r_out_last;

    logic       has_result, out_free, go;
    logic       res_valid;
    logic [7:0] res_mosi;
    logic [2:0] res_sel, res_ph;
    logic       res_last;
    logic       mem_we;
    logic       go_next, go_bcst, go_poll, go_send;
    logic [2:0] send_sel, send_ph, rt_sel, nb, n_peers;
    logic [7:0] hdr_len, rt_type;
    logic [8:0] cnt_inc, len_sum, rlen, idx, idx_inc;
    logic [8:0] rd_addr;

    assign has_result = (r_in_action == spisfr_pkg::ACT_START)
                     || (r_in_action == spisfr_pkg::ACT_XFER);
    assign out_free   = !r_out_valid || m_axis_tready;
    assign go         = r_in_valid && (!has_result || out_free);
    assign s_axis_tready = !r_in_valid || go;

    assign cnt_inc = r_count + 9'd1;
    // length byte arrives this step when byte 3 is being received
    assign hdr_len = (r_state == spisfr_pkg::ST_RECV && r_count == 9'd3) ? r_in_rx : r_hdr[3];
    assign len_sum = 9'd4 + {1'b0, hdr_len};
    assign rlen    = (len_sum < BUF_CNT) ? len_sum : BUF_CNT;
    assign rt_type = r_hdr[2];
    assign rt_sel  = (rt_type == spisfr_pkg::T_HOST) ? spisfr_pkg::SEL_HOST
                                                     : spisfr_pkg::addr_to_peer(r_hdr[1]);
    assign nb      = r_bidx + 3'd1;
    assign n_peers = (r_polled_peers == 3'd0) ? 3'd1
                   : (r_polled_peers > spisfr_pkg::MAX_PEERS) ? spisfr_pkg::MAX_PEERS
                   : r_polled_peers;

    always_comb begin
        n_state   = r_state;
        n_peer    = r_peer;
        n_timer   = r_timer;
        n_expired = r_expired;
        n_count   = r_count;
        n_target  = r_target;
        n_bidx    = r_bidx;
        n_bafter  = r_bafter;
        res_valid = 1'b0;
        res_mosi  = 8'd0;
        res_sel   = 3'd0;
        res_ph    = 3'd0;
        res_last  = 1'b0;
        mem_we    = 1'b0;
        go_next   = 1'b0;
        go_bcst   = 1'b0;
        go_poll   = 1'b0;
        go_send   = 1'b0;
        send_sel  = 3'd0;
        send_ph   = 3'd0;
        idx       = 9'd0;
        idx_inc   = 9'd0;
        if (go) begin
            unique case (r_in_action)
                spisfr_pkg::ACT_TICK: begin
                    if (r_timer != spisfr_pkg::TIMER_MAX) n_timer = r_timer + 16'd1;
                end
                spisfr_pkg::ACT_START: begin
                    n_timer   = 16'd0;
                    n_expired = 1'b0;
                    n_count   = 9'd0;
                    n_target  = spisfr_pkg::SEL_NONE;
                    n_bafter  = 1'b0;
                    n_bidx    = 3'd0;
                    go_poll   = 1'b1;
                end
                spisfr_pkg::ACT_XFER: begin
                    unique case (r_state)
                        spisfr_pkg::ST_POLL: begin
                            if (r_in_rx == spisfr_pkg::B_POLL_ACK) begin
                                n_state   = spisfr_pkg::ST_RECV;
                                n_count   = 9'd0;
                                res_valid = 1'b1;
                                res_mosi  = spisfr_pkg::B_FILL;
                                res_sel   = r_peer;
                                res_ph    = spisfr_pkg::PH_RECV;
                            end else begin
                                go_next = 1'b1;
                            end
                        end
                        spisfr_pkg::ST_RECV: begin
                            mem_we  = r_count < BUF_CNT;
                            n_count = cnt_inc;
                            if (cnt_inc >= 9'd4 && cnt_inc == len_sum) begin
                                if (rt_type == spisfr_pkg::T_DIRECT
                                        || rt_type == spisfr_pkg::T_HOST
                                        || rt_type == spisfr_pkg::T_DIR_BCAST) begin
                                    n_target = rt_sel;
                                    n_bafter = rt_type == spisfr_pkg::T_DIR_BCAST;
                                    if (rt_sel == spisfr_pkg::SEL_NONE) begin
                                        if (rt_type == spisfr_pkg::T_DIR_BCAST) go_bcst = 1'b1;
                                        else go_next = 1'b1;
                                    end else begin
                                        n_state   = spisfr_pkg::ST_HAND;
                                        res_valid = 1'b1;
                                        res_mosi  = spisfr_pkg::B_HAND;
                                        res_sel   = rt_sel;
                                        res_ph    = spisfr_pkg::PH_HAND;
                                    end
                                end else if (rt_type == spisfr_pkg::T_BCAST) begin
                                    go_bcst = 1'b1;
                                end else begin
                                    go_next = 1'b1;
                                end
                            end else begin
                                res_valid = 1'b1;
                                res_mosi  = spisfr_pkg::B_FILL;
                                res_sel   = r_peer;
                                res_ph    = spisfr_pkg::PH_RECV;
                            end
                        end
                        spisfr_pkg::ST_HAND: begin
                            if (r_in_rx == spisfr_pkg::B_HAND_ACK) begin
                                n_state  = spisfr_pkg::ST_SEND;
                                n_count  = 9'd0;
                                go_send  = 1'b1;
                                send_sel = r_target;
                                send_ph  = spisfr_pkg::PH_SEND;
                            end else begin
                                res_valid = 1'b1;
                                res_mosi  = spisfr_pkg::B_HAND;
                                res_sel   = r_target;
                                res_ph    = spisfr_pkg::PH_HAND;
                            end
                        end
                        spisfr_pkg::ST_SEND: begin
                            n_count = cnt_inc;
                            if (cnt_inc >= rlen) begin
                                if (r_bafter) go_bcst = 1'b1;
                                else go_next = 1'b1;
                            end else begin
                                go_send  = 1'b1;
                                send_sel = r_target;
                                send_ph  = spisfr_pkg::PH_SEND;
                            end
                        end
                        spisfr_pkg::ST_BCST: begin
                            n_count = cnt_inc;
                            if (cnt_inc >= rlen) begin
                                n_bidx = nb;
                                if (nb >= spisfr_pkg::BCST_CLIENTS) begin
                                    go_next = 1'b1;
                                end else begin
                                    n_count  = 9'd0;
                                    go_send  = 1'b1;
                                    send_sel = nb + 3'd1;
                                    send_ph  = spisfr_pkg::PH_BCST;
                                end
                            end else begin
                                go_send  = 1'b1;
                                send_sel = r_bidx + 3'd1;
                                send_ph  = spisfr_pkg::PH_BCST;
                            end
                        end
                        default: go_next = 1'b1;
                    endcase
                end
                default: ;
            endcase
        end

        // start of a broadcast: client 1 first, from byte 0
        if (go_bcst) begin
            n_state  = spisfr_pkg::ST_BCST;
            n_bidx   = 3'd0;
            n_count  = 9'd0;
            go_send  = 1'b1;
            send_sel = 3'd1;
            send_ph  = spisfr_pkg::PH_BCST;
        end
        // end of a round: an expired window moves to the next peer
        if (go_next) begin
            n_target = spisfr_pkg::SEL_NONE;
            n_bafter = 1'b0;
            n_count  = 9'd0;
            if (n_expired) begin
                n_peer    = (r_peer + 3'd1 >= n_peers) ? 3'd0 : r_peer + 3'd1;
                n_timer   = 16'd0;
                n_expired = 1'b0;
            end
            go_poll = 1'b1;
        end
        if (go_poll) begin
            n_state = spisfr_pkg::ST_POLL;
            if (n_timer >= r_poll_window) n_expired = 1'b1;
            res_valid = 1'b1;
            res_mosi  = spisfr_pkg::B_POLL;
            res_sel   = n_peer;
            res_ph    = spisfr_pkg::PH_POLL;
        end
        if (go_send) begin
            idx       = n_count;
            idx_inc   = n_count + 9'd1;
            res_valid = 1'b1;
            if (idx < 9'd4) res_mosi = r_hdr[idx[1:0]];
            else if (idx < BUF_CNT) res_mosi = r_rd;
            else res_mosi = 8'd0;
            res_sel   = send_sel;
            res_ph    = send_ph;
            res_last  = idx_inc == rlen;
        end
    end

    // prefetch the byte the next step may send
    assign rd_addr = n_count + 9'd1;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_count[AW-1:0]] <= r_in_rx;
        r_rd <= r_mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && r_count < 9'd4) r_hdr[r_count[1:0]] <= r_in_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_window  <= spisfr_pkg::WINDOW_RESET;
            r_polled_peers <= spisfr_pkg::PEERS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spisfr_pkg::REG_POLL_WINDOW:  r_poll_window  <= i_cfg_data;
                spisfr_pkg::REG_POLLED_PEERS: r_polled_peers <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= spisfr_pkg::ST_POLL;
            r_peer      <= spisfr_pkg::SEL_HOST;
            r_timer     <= 16'd0;
            r_expired   <= 1'b0;
            r_count     <= 9'd0;
            r_target    <= spisfr_pkg::SEL_NONE;
            r_bidx      <= 3'd0;
            r_bafter    <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (res_valid) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            r_state   <= n_state;
            r_peer    <= n_peer;
            r_timer   <= n_timer;
            r_expired <= n_expired;
            r_count   <= n_count;
            r_target  <= n_target;
            r_bidx    <= n_bidx;
            r_bafter  <= n_bafter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= s_axis_tuser;
            r_in_rx     <= s_axis_tdata;
        end
        if (res_valid) begin
            r_out_mosi <= res_mosi;
            r_out_sel  <= res_sel;
            r_out_ph   <= res_ph;
            r_out_last <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_mosi;
    assign m_axis_tuser  = {r_out_ph, r_out_sel};
    assign m_axis_tlast  = r_out_last;

endmodule
